// ----- design/ubxfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ubxfe_pkg;

  // Wire constants of a UBX frame
  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;
  localparam logic [7:0] LenHigh    = 8'h00;

  // Item modes
  localparam logic ModeHeader  = 1'b0;
  localparam logic ModePayload = 1'b1;

  // Command queue between front and back
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  // Byte positions within a header command; a payload command maps onto
  // the class slot for its byte and onto the checksum slots for CK_A/CK_B
  localparam logic [2:0] PosSyncFirst  = 3'd0;
  localparam logic [2:0] PosSyncSecond = 3'd1;
  localparam logic [2:0] PosClass      = 3'd2;
  localparam logic [2:0] PosId         = 3'd3;
  localparam logic [2:0] PosLenLow     = 3'd4;
  localparam logic [2:0] PosLenHigh    = 3'd5;
  localparam logic [2:0] PosCkA        = 3'd6;
  localparam logic [2:0] PosCkB        = 3'd7;

  typedef struct packed {
    logic       mode;
    logic [7:0] cls_byte;
    logic [7:0] msg_id;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } ubxfe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } ubxfe_out_t;

  // One classified transaction, ready for serialization
  typedef struct packed {
    logic       is_hdr;
    logic       add_ck;
    logic [7:0] b0;    // class, or the payload byte
    logic [7:0] b1;    // id
    logic [7:0] b2;    // length low
    logic [7:0] ck_a;
    logic [7:0] ck_b;
  } ubxfe_cmd_t;

  // Select the wire byte at a slot position
  function automatic logic [7:0] ubxfe_slot_byte(input logic [2:0] pos,
                                                 input ubxfe_cmd_t cmd);
    logic [7:0] b;
    unique case (pos)
      PosSyncFirst:  b = SyncFirst;
      PosSyncSecond: b = SyncSecond;
      PosClass:      b = cmd.b0;
      PosId:         b = cmd.b1;
      PosLenLow:     b = cmd.b2;
      PosLenHigh:    b = LenHigh;
      PosCkA:        b = cmd.ck_a;
      PosCkB:        b = cmd.ck_b;
      default:       b = LenHigh;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- design/ubx_frame_encoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// The first byte of a transaction passes through the command queue and the output register.
// Throughput: one output byte per cycle while results are popped, set by the back-end
// serializer; a payload item yields one byte, or three with CK_A/CK_B; a header 6 or 8.
// A four-entry command queue lets input run ahead of a stalled output.
// Reset (rst_ni low, asynchronous): no frame open, sums zero, queue and output empty.
module ubx_frame_encoder import ubxfe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire ubxfe_in_t  item_i,
  output logic            empty,
  input  wire logic       pop,
  output ubxfe_out_t      result_o
);

  logic        accept;
  logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
  ubxfe_cmd_t  cmd_wr, cmd_rd;

  assign full = cmd_full;

  // Classify items and track the open frame
  ubxfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .cmd_full_i (cmd_full),
    .accept_o   (accept),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  // Decouple front and back
  ubxfe_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push && accept),
    .cmd_i   (cmd_wr),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd_rd)
  );

  // Serialize commands into wire bytes
  ubxfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// ----- design/ubxfe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ubxfe_front import ubxfe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire ubxfe_in_t  item_i,
  input  wire logic       cmd_full_i,
  output logic            accept_o,
  output logic            cmd_push_o,
  output ubxfe_cmd_t      cmd_o
);

  logic       in_frame_q, in_frame_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] sum_a_q, sum_a_d;
  logic [7:0] sum_b_q, sum_b_d;

  logic [7:0] hdr_a, hdr_b;
  logic [7:0] cls_x4, id_x3, len_x2;
  logic [7:0] pay_a, pay_b, left_dec;

  assign accept_o = push_i && !cmd_full_i;

  // Fletcher sums over class, id, length low and a zero length high
  always_comb begin
    cls_x4 = {item_i.cls_byte[5:0], 2'b00};
    id_x3  = {item_i.msg_id[6:0], 1'b0} + item_i.msg_id;
    len_x2 = {item_i.payload_length[6:0], 1'b0};
    hdr_a  = item_i.cls_byte + item_i.msg_id + item_i.payload_length;
    hdr_b  = cls_x4 + id_x3 + len_x2;
  end

  // Fletcher step for one payload byte
  always_comb begin
    pay_a    = sum_a_q + item_i.payload_byte;
    pay_b    = sum_b_q + pay_a;
    left_dec = bytes_left_q - 8'd1;
  end

  // Classify the transaction and build the command
  always_comb begin
    in_frame_d   = in_frame_q;
    bytes_left_d = bytes_left_q;
    sum_a_d      = sum_a_q;
    sum_b_d      = sum_b_q;
    cmd_push_o   = 1'b0;
    cmd_o        = '0;
    if (item_i.mode == ModeHeader) begin
      cmd_o.is_hdr = 1'b1;
      cmd_o.add_ck = (item_i.payload_length == 8'd0);
      cmd_o.b0     = item_i.cls_byte;
      cmd_o.b1     = item_i.msg_id;
      cmd_o.b2     = item_i.payload_length;
      cmd_o.ck_a   = hdr_a;
      cmd_o.ck_b   = hdr_b;
      if (accept_o) begin
        cmd_push_o   = 1'b1;
        in_frame_d   = (item_i.payload_length != 8'd0);
        bytes_left_d = item_i.payload_length;
        sum_a_d      = hdr_a;
        sum_b_d      = hdr_b;
      end
    end else begin
      cmd_o.is_hdr = 1'b0;
      cmd_o.add_ck = (left_dec == 8'd0);
      cmd_o.b0     = item_i.payload_byte;
      cmd_o.ck_a   = pay_a;
      cmd_o.ck_b   = pay_b;
      // Drop payload bytes that arrive outside a frame
      if (accept_o && in_frame_q) begin
        cmd_push_o   = 1'b1;
        in_frame_d   = (left_dec != 8'd0);
        bytes_left_d = left_dec;
        sum_a_d      = pay_a;
        sum_b_d      = pay_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      bytes_left_q <= '0;
      sum_a_q      <= '0;
      sum_b_q      <= '0;
    end else begin
      in_frame_q   <= in_frame_d;
      bytes_left_q <= bytes_left_d;
      sum_a_q      <= sum_a_d;
      sum_b_q      <= sum_b_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/ubxfe_cmd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ubxfe_cmd_fifo import ubxfe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire ubxfe_cmd_t  cmd_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output ubxfe_cmd_t       cmd_o
);

  ubxfe_cmd_t           entry_q [CmdDepth];
  logic [CmdPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CmdCntW'(CmdDepth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store the command at the tail
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/ubxfe_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ubxfe_back import ubxfe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_empty_i,
  input  wire ubxfe_cmd_t  cmd_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  wire logic        pop_i,
  output ubxfe_out_t       result_o
);

  logic [2:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  ubxfe_out_t  out_q, out_d;
  logic [2:0]  pos;
  logic        last;
  logic        can_load, emit;

  // Map the step index onto a slot position
  always_comb begin
    if (cmd_i.is_hdr) begin
      pos = idx_q;
    end else if (idx_q == 3'd0) begin
      pos = PosClass;
    end else begin
      pos = idx_q + 3'd5;
    end
    last = (pos == PosCkB)
        || (!cmd_i.add_ck && cmd_i.is_hdr && (pos == PosLenHigh))
        || (!cmd_i.add_ck && !cmd_i.is_hdr && (pos == PosClass));
  end

  assign can_load  = !out_valid_q || pop_i;
  assign emit      = !cmd_empty_i && can_load;
  assign cmd_pop_o = emit && last;
  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;

  // Serialize the head command one byte per cycle while the output is free or popped
  always_comb begin
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      idx_d           = last ? 3'd0 : idx_q + 3'd1;
      out_d.out_byte  = ubxfe_slot_byte(pos, cmd_i);
      out_d.run_last  = last;
      out_d.frame_end = (pos == PosCkB);
      out_valid_d     = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire

// ----- design/ubxfe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ubxfe_checker import ubxfe_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire ubxfe_out_t result_o
);

  // CK_B always closes the transaction that produced it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.frame_end) |-> result_o.run_last)
    else $error("frame_end without run_last");

  // Hold a waiting result until it is popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("stalled result changed");

  // Come out of reset with nothing to show
  assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result shown right after reset");

endmodule

bind ubx_frame_encoder ubxfe_checker u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

`default_nettype wire
